// File: rtl/core/kct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed completion table.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int ENTRIES   = 16;
  localparam int ID_BITS   = 32;
  localparam int DATA_BITS = 32;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int KIND_W = 3;
  localparam int KEY_W  = ID_BITS + KIND_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ACT_PUBLISH = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_LOOKUP  = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    KIND_MESH     = 3'd2,
    KIND_MATERIAL = 3'd3,
    KIND_TEXTURE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_PUBLISHED = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_INVALID   = 3'd3,
    ST_MISSING   = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_NOTFOUND  = 3'd6,
    ST_FULL      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic    do_insert;
    logic    do_update;
    logic    do_remove;
    logic    do_clear;
    status_t status;
  } commit_t;

endpackage
`default_nettype wire

// File: rtl/core/kct_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_req_if / kct_res_if
// Valid/ready channels carrying table requests and their results.
// ----------------------------------------------------------------------------
interface kct_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] asset_id;
  logic [2:0]  asset_kind;
  logic        load_ok;
  logic        handle_valid;
  logic [31:0] payload;

  modport source (
    output valid, action, asset_id, asset_kind, load_ok, handle_valid, payload,
    input  ready
  );
  modport sink (
    input  valid, action, asset_id, asset_kind, load_ok, handle_valid, payload,
    output ready
  );
endinterface

interface kct_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [31:0] found_payload;
  logic [4:0]  entry_count;

  modport source (
    output valid, status, found, found_payload, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, found, found_payload, entry_count,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/keyed_completion_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_completion_table
// Keyed record table with publish, replace, remove, lookup and clear.
// ----------------------------------------------------------------------------
// One request is handled at a time. Valid bits sit in flip-flops; keys and
// payloads sit in memories with one read port and one write port, which a
// sequencer reads one entry per cycle, feeding a single key comparator. A
// request with a valid key and action 0 to 3 scans until the key is found
// or the last slot is compared, then commits; clear, invalid and undefined
// requests skip the scan and go straight to the write state. The
// next request may be accepted while the previous result still waits in the
// output register, but it cannot finish until that result has been taken.
module keyed_completion_table
  import kct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  kct_req_if.sink    req,
  kct_res_if.source  res
);

  state_t state, state_next;

  logic [ENTRIES-1:0]   entry_valid;
  logic [KEY_W-1:0]     key_mem  [ENTRIES];
  logic [DATA_BITS-1:0] data_mem [ENTRIES];
  logic [CNT_W-1:0]     valid_count;

  action_t              req_action;
  logic [KEY_W-1:0]     req_key;
  logic                 req_handle;
  logic                 req_key_ok;
  logic [DATA_BITS-1:0] req_data;

  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_done;
  logic [IDX_W-1:0]     cmp_addr;
  logic                 cmp_live;
  logic [KEY_W-1:0]     key_rd;
  logic [DATA_BITS-1:0] data_rd;

  logic                 hit;
  logic [IDX_W-1:0]     hit_addr;
  logic [DATA_BITS-1:0] hit_data;
  logic                 free_ok;
  logic [IDX_W-1:0]     free_addr;

  logic                 hit_now;
  logic                 free_now;
  logic                 scan_end;
  logic                 out_free;
  logic                 accept;
  logic                 commit_go;
  logic                 in_key_ok;
  logic                 need_scan;
  commit_t              cm;
  logic [IDX_W-1:0]     wr_addr;

  assign out_free  = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign in_key_ok = (req.asset_id[ID_BITS > 32 ? 31 : ID_BITS-1:0] != '0) &&
                     (req.asset_kind == KIND_MESH || req.asset_kind == KIND_MATERIAL ||
                      req.asset_kind == KIND_TEXTURE);
  assign need_scan = in_key_ok && (req.action <= ACT_LOOKUP);

  assign hit_now  = cmp_live && entry_valid[cmp_addr] && (key_rd == req_key);
  assign free_now = cmp_live && !entry_valid[cmp_addr];
  assign scan_end = hit_now || (cmp_live && cmp_addr == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = need_scan ? S_SCAN : S_WRITE;
      S_SCAN:  if (scan_end) state_next = S_WRITE;
      S_WRITE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    commit_go = 1'b0;
    unique case (state)
      S_IDLE:  req.ready = 1'b1;
      S_SCAN:  ;
      S_WRITE: commit_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action_t'(req.action);
      req_key    <= {ID_BITS'(req.asset_id), req.asset_kind};
      req_handle <= req.load_ok && req.handle_valid;
      req_key_ok <= in_key_ok;
      req_data   <= DATA_BITS'(req.payload);
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
      rd_done  <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end else if (accept) begin
      rd_addr  <= '0;
      rd_done  <= 1'b0;
      cmp_live <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end else if (state == S_SCAN) begin
      cmp_addr <= rd_addr;
      cmp_live <= !rd_done && !scan_end;
      if (rd_addr == LAST_IDX) rd_done <= 1'b1;
      else                     rd_addr <= rd_addr + 1'b1;
      if (hit_now) begin
        hit      <= 1'b1;
        hit_addr <= cmp_addr;
        hit_data <= data_rd;
      end
      if (free_now && !free_ok) begin
        free_ok   <= 1'b1;
        free_addr <= cmp_addr;
      end
    end else begin
      cmp_live <= 1'b0;
    end
  end

  // commit decode
  always_comb begin
    cm = '{do_insert: 1'b0, do_update: 1'b0, do_remove: 1'b0, do_clear: 1'b0,
           status: ST_INVALID};
    if (req_action == ACT_CLEAR) begin
      cm.do_clear = 1'b1;
      cm.status   = ST_REMOVED;
    end else if (req_key_ok) begin
      unique case (req_action)
        ACT_PUBLISH, ACT_REPLACE: begin
          if (!req_handle) cm.status = ST_MISSING;
          else if (hit) begin
            if (req_action == ACT_PUBLISH) cm.status = ST_ALREADY;
            else begin
              cm.do_update = 1'b1;
              cm.status    = ST_REPLACED;
            end
          end else if (free_ok) begin
            cm.do_insert = 1'b1;
            cm.status    = ST_PUBLISHED;
          end else cm.status = ST_FULL;
        end
        ACT_REMOVE: begin
          cm.do_remove = hit;
          cm.status    = hit ? ST_REMOVED : ST_NOTFOUND;
        end
        ACT_LOOKUP: cm.status = hit ? ST_ALREADY : ST_NOTFOUND;
        default:    cm.status = ST_INVALID;
      endcase
    end
  end

  assign wr_addr = cm.do_insert ? free_addr : hit_addr;

  // key and payload memories
  always_ff @(posedge clk) begin
    key_rd  <= key_mem[rd_addr];
    data_rd <= data_mem[rd_addr];
    if (commit_go && cm.do_insert) key_mem[wr_addr] <= req_key;
    if (commit_go && (cm.do_insert || cm.do_update)) data_mem[wr_addr] <= req_data;
  end

  // valid bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
    end else if (commit_go) begin
      if (cm.do_clear) begin
        entry_valid <= '0;
        valid_count <= '0;
      end else if (cm.do_insert) begin
        entry_valid[free_addr] <= 1'b1;
        valid_count            <= valid_count + 1'b1;
      end else if (cm.do_remove) begin
        entry_valid[hit_addr] <= 1'b0;
        if (valid_count != '0) valid_count <= valid_count - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (commit_go) res.valid <= 1'b1;
    else if (res.ready) res.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      res.status        <= cm.status;
      res.found         <= hit && req_key_ok && (req_action <= ACT_LOOKUP);
      res.found_payload <= (hit && req_key_ok && req_action == ACT_LOOKUP) ?
                           32'(hit_data) : 32'd0;
      if (cm.do_clear)       res.entry_count <= 5'd0;
      else if (cm.do_insert) res.entry_count <= 5'(valid_count + 1'b1);
      else if (cm.do_remove && valid_count != '0)
                             res.entry_count <= 5'(valid_count - 1'b1);
      else                   res.entry_count <= 5'(valid_count);
    end
  end

endmodule
`default_nettype wire

// File: tb/keyed_completion_table_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_completion_table_tb
// Self-checking testbench for the keyed completion table. Requests are sent
// on the request channel with random gaps, and results are taken with random
// back-pressure. A behavioural copy of the table predicts every result, and
// the result channel is compared field by field against it. Directed tests
// cover an empty table, bad keys, missing handles, the life of a key, clear
// and a full table. Random traffic then runs over a small pool of keys so
// that hits, refills and the full case come up often.
// ----------------------------------------------------------------------------
module keyed_completion_table_tb;
  import kct_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 1700;
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_TERRAIN = 3'd1;
  localparam logic [2:0] KIND_SHADER = 3'd7;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] found_payload;
    logic [4:0]  entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;

  kct_req_if req_ch ();
  kct_res_if res_ch ();

  keyed_completion_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #1 clk = ~clk;

  // behavioural copy of the table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_id    [ENTRIES];
  logic [2:0]  tbl_kind  [ENTRIES];
  logic [31:0] tbl_data  [ENTRIES];
  int          tbl_count;

  table_result_t pending_outcomes [$];
  int            errors;
  int            cycle_count;
  bit            no_idle;

  logic [31:0] pool_id   [24];
  logic [2:0]  pool_kind [24];
  int          pool_size;

  function automatic table_result_t predict_outcome(logic [2:0] action, logic [31:0] id,
                                                    logic [2:0] kind, logic lok, logic hv,
                                                    logic [31:0] pay);
    table_result_t r;
    int hit;
    int slot;
    bit key_ok;
    hit = -1;
    slot = -1;
    r = '0;
    r.status = ST_INVALID;
    key_ok = (id != 0) && (kind == KIND_MESH || kind == KIND_MATERIAL || kind == KIND_TEXTURE);
    if (action <= ACT_LOOKUP && key_ok) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_id[i] == id && tbl_kind[i] == kind) hit = i;
      end
      r.found = (hit >= 0);
    end
    if (action == ACT_CLEAR) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_count = 0;
      r.status = ST_REMOVED;
    end else if (action > ACT_CLEAR || !key_ok) begin
      r.status = ST_INVALID;
    end else if (action == ACT_PUBLISH || action == ACT_REPLACE) begin
      if (!(lok && hv)) begin
        r.status = ST_MISSING;
      end else if (hit >= 0) begin
        if (action == ACT_PUBLISH) begin
          r.status = ST_ALREADY;
        end else begin
          tbl_data[hit] = pay;
          r.status = ST_REPLACED;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot] = id;
          tbl_kind[slot] = kind;
          tbl_data[slot] = pay;
          tbl_count++;
          r.status = ST_PUBLISHED;
        end
      end
    end else if (action == ACT_REMOVE) begin
      if (hit >= 0) begin
        tbl_valid[hit] = 1'b0;
        if (tbl_count > 0) tbl_count--;
        r.status = ST_REMOVED;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end else begin
      if (hit >= 0) begin
        r.found_payload = tbl_data[hit];
        r.status = ST_ALREADY;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    r.entry_count = 5'(tbl_count);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called just after a rising edge; returns at the edge the request is taken
  task automatic issue_request(logic [2:0] action, logic [31:0] id, logic [2:0] kind,
                               logic lok, logic hv, logic [31:0] pay);
    int gap;
    table_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= action;
    req_ch.asset_id     <= id;
    req_ch.asset_kind   <= kind;
    req_ch.load_ok      <= lok;
    req_ch.handle_valid <= hv;
    req_ch.payload      <= pay;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_outcome(action, id, kind, lok, hv, pay);
    pending_outcomes = {pending_outcomes, predicted};
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  task automatic test_empty_table();
    issue_request(ACT_LOOKUP, 32'd1, KIND_MESH, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_REMOVE, 32'hffff_ffff, KIND_TEXTURE, 1'b0, 1'b0, 32'hffff_ffff);
  endtask

  task automatic test_invalid_requests();
    issue_request(ACT_PUBLISH, 32'd0, KIND_MESH, 1'b1, 1'b1, 32'h1234_5678);
    issue_request(ACT_LOOKUP, 32'd5, KIND_UNKNOWN, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_REPLACE, 32'hffff_ffff, KIND_SHADER, 1'b1, 1'b1, 32'hffff_ffff);
    issue_request(ACT_REMOVE, 32'd9, KIND_TERRAIN, 1'b1, 1'b1, 32'd0);
    for (int a = int'(ACT_CLEAR) + 1; a < 8; a++) begin
      issue_request(3'(a), 32'd7, KIND_MATERIAL, 1'b1, 1'b1, 32'hdead_beef);
    end
  endtask

  task automatic test_missing_handle();
    issue_request(ACT_PUBLISH, 32'd3, KIND_MESH, 1'b0, 1'b1, 32'h0000_0001);
    issue_request(ACT_REPLACE, 32'd3, KIND_MESH, 1'b1, 1'b0, 32'h0000_0002);
  endtask

  task automatic test_key_lifecycle();
    issue_request(ACT_PUBLISH, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b1, 32'hffff_ffff);
    issue_request(ACT_PUBLISH, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_LOOKUP, 32'hffff_ffff, KIND_TEXTURE, 1'b0, 1'b0, 32'd0);
    issue_request(ACT_REPLACE, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_REPLACE, 32'd1, KIND_MATERIAL, 1'b1, 1'b1, 32'h1234_5678);
    // handle missing on a present key still reports it as found
    issue_request(ACT_PUBLISH, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b0, 32'h5555_5555);
    issue_request(ACT_LOOKUP, 32'hffff_ffff, KIND_MESH, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_REMOVE, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_REMOVE, 32'hffff_ffff, KIND_TEXTURE, 1'b1, 1'b1, 32'd0);
    issue_request(ACT_LOOKUP, 32'd1, KIND_MATERIAL, 1'b1, 1'b1, 32'd0);
  endtask

  task automatic test_clear();
    issue_request(ACT_CLEAR, $urandom, 3'($urandom), 1'($urandom), 1'($urandom), $urandom);
    issue_request(ACT_LOOKUP, 32'd1, KIND_MATERIAL, 1'b1, 1'b1, 32'd0);
  endtask

  task automatic test_table_full();
    logic [31:0] ids   [ENTRIES + 1];
    logic [2:0]  kinds [ENTRIES + 1];
    for (int i = 0; i <= ENTRIES; i++) begin
      ids[i] = {27'($urandom), 5'(i + 1)};
      kinds[i] = 3'($urandom_range(KIND_MESH, KIND_TEXTURE));
      issue_request(ACT_PUBLISH, ids[i], kinds[i], 1'b1, 1'b1, $urandom);
    end
    issue_request(ACT_REPLACE, ids[0] ^ 32'h8000_0000, kinds[0], 1'b1, 1'b1, $urandom);
    issue_request(ACT_REPLACE, ids[ENTRIES - 1], kinds[ENTRIES - 1], 1'b1, 1'b1, $urandom);
    issue_request(ACT_REMOVE, ids[5], kinds[5], 1'b1, 1'b1, 32'd0);
    issue_request(ACT_PUBLISH, ids[ENTRIES], kinds[ENTRIES], 1'b1, 1'b1, $urandom);
    issue_request(ACT_LOOKUP, ids[ENTRIES], kinds[ENTRIES], 1'b1, 1'b1, 32'd0);
    issue_request(ACT_LOOKUP, ids[ENTRIES - 1], kinds[ENTRIES - 1], 1'b1, 1'b1, 32'd0);
    issue_request(ACT_CLEAR, 32'd0, KIND_UNKNOWN, 1'b0, 1'b0, 32'd0);
  endtask

  task automatic test_random_traffic(int n_items);
    int r;
    int k;
    logic [2:0]  act;
    logic [31:0] id;
    logic [2:0]  kind;
    logic        lok;
    logic        hv;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) begin
        pool_size = ($urandom_range(0, 2) == 0) ? 8 : 22;
        for (int j = 0; j < pool_size; j++) begin
          if (j > 0 && j % 5 == 0) pool_id[j] = pool_id[j - 1] ^ (32'd1 << $urandom_range(0, 31));
          else if (j % 7 == 3) pool_id[j] = pool_id[j - 1];
          else if (j == 0 && $urandom_range(0, 1) == 1) pool_id[j] = 32'hffff_ffff;
          else pool_id[j] = $urandom;
          if (pool_id[j] == 0) pool_id[j] = 32'd1;
          pool_kind[j] = 3'($urandom_range(KIND_MESH, KIND_TEXTURE));
        end
      end
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        k = $urandom_range(0, pool_size - 1);
        id = pool_id[k];
        kind = pool_kind[k];
        r = $urandom_range(0, 99);
        if (r < 30) act = ACT_PUBLISH;
        else if (r < 55) act = ACT_REPLACE;
        else if (r < 75) act = ACT_REMOVE;
        else act = ACT_LOOKUP;
        lok = ($urandom_range(0, 19) != 0);
        hv = ($urandom_range(0, 19) != 0);
      end else if (r < 82) begin
        act = ACT_CLEAR;
        id = $urandom;
        kind = 3'($urandom);
        lok = 1'($urandom);
        hv = 1'($urandom);
      end else begin
        act = 3'($urandom_range(0, 7));
        id = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        kind = 3'($urandom_range(0, 7));
        lok = 1'($urandom);
        hv = 1'($urandom);
      end
      issue_request(act, id, kind, lok, hv, $urandom);
    end
    no_idle = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      gap = pick_gap();
      if (gap == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 res_ch.status);
      end else begin
        exp_r = pending_outcomes.pop_front();
        check_field("status", 32'(exp_r.status), 32'(res_ch.status));
        check_field("found", 32'(exp_r.found), 32'(res_ch.found));
        check_field("found_payload", exp_r.found_payload, res_ch.found_payload);
        check_field("entry_count", 32'(exp_r.entry_count), 32'(res_ch.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    errors = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    tbl_count = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_LOOKUP;
    req_ch.asset_id = '0;
    req_ch.asset_kind = KIND_UNKNOWN;
    req_ch.load_ok = 1'b0;
    req_ch.handle_valid = 1'b0;
    req_ch.payload = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_invalid_requests();
    test_missing_handle();
    test_key_lifecycle();
    test_clear();
    test_table_full();
    test_random_traffic(RANDOM_REQUESTS);
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (pending_outcomes.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
